>>> rtl/srg_pkg.sv
package srg_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_BANK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_SCREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCR_HEIGHT  = 2'd3;

	localparam logic [10:0] SCR_WIDTH_RST  = 11'd320;
	localparam logic [10:0] SCR_HEIGHT_RST = 11'd240;

	// descriptor queue depth between decode and row sequencer
	localparam int QUEUE_DEPTH = 2;

	// priority codes and their masks
	localparam logic [1:0] PRI_0 = 2'd0;
	localparam logic [1:0] PRI_1 = 2'd1;
	localparam logic [1:0] PRI_2 = 2'd2;
	localparam logic [1:0] PRI_3 = 2'd3;
	localparam logic [7:0] PRI_MASK_0 = 8'h00;
	localparam logic [7:0] PRI_MASK_1 = 8'hf0;
	localparam logic [7:0] PRI_MASK_2 = 8'hf0 | 8'hcc;
	localparam logic [7:0] PRI_MASK_3 = 8'hf0 | 8'hcc | 8'haa;

	localparam logic [7:0] ZOOM_FULL = 8'd128;

	// decoded sprite, one per visible list entry
	typedef struct packed {
		logic [18:0] code;
		logic [11:0] sx;
		logic [11:0] sy;
		logic [4:0]  xnum;
		logic [3:0]  ylast;
		logic        fx;
		logic        fy;
		logic [5:0]  color;
		logic [7:0]  pri;
		logic [7:0]  xzoom;
		logic [7:0]  yzoom;
	} srg_desc_t;

	// draw scale: 512 * (zoom + 8)
	function automatic logic [16:0] scale_of(input logic [7:0] zoom);
		logic [8:0] z8;
		z8 = {1'b0, zoom} + 9'd8;
		return 17'({z8, 9'b0});
	endfunction

endpackage

>>> rtl/srg_front.sv
module srg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [srg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [15:0]                   x_word,
	input  logic [15:0]                   y_word,
	input  logic [15:0]                   attr_word,
	input  logic [15:0]                   code_word,
	output logic                          push,
	input  logic                          push_ready,
	output srg_pkg::srg_desc_t            push_desc
);

	logic [15:0] tile_bank_q;
	logic        flip_screen_q;
	logic [10:0] scr_width_q;
	logic [10:0] scr_height_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_bank_q   <= '0;
			flip_screen_q <= 1'b0;
			scr_width_q   <= srg_pkg::SCR_WIDTH_RST;
			scr_height_q  <= srg_pkg::SCR_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srg_pkg::CFG_TILE_BANK:   tile_bank_q   <= cfg_data;
				srg_pkg::CFG_FLIP_SCREEN: flip_screen_q <= cfg_data[0];
				srg_pkg::CFG_SCR_WIDTH:   scr_width_q   <= cfg_data[10:0];
				srg_pkg::CFG_SCR_HEIGHT:  scr_height_q  <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	logic        hide;
	logic [1:0]  sel;
	logic [3:0]  bank;
	logic [4:0]  xnum;
	logic [4:0]  ynum;
	logic [11:0] sx_raw;
	logic [11:0] sy_raw;
	logic [7:0]  pri;

	// decode the list entry
	always_comb begin
		hide   = x_word[10];
		sel    = code_word[15:14];
		bank   = tile_bank_q[{sel, 2'b00} +: 4];
		xnum   = {1'b0, x_word[15:12]} + 5'd1;
		ynum   = {1'b0, y_word[15:12]} + 5'd1;
		sx_raw = {{2{x_word[9]}}, x_word[9:0]};
		sy_raw = {{2{y_word[9]}}, y_word[9:0]};
		unique case (attr_word[7:6])
			srg_pkg::PRI_3: pri = srg_pkg::PRI_MASK_3;
			srg_pkg::PRI_2: pri = srg_pkg::PRI_MASK_2;
			srg_pkg::PRI_1: pri = srg_pkg::PRI_MASK_1;
			default:        pri = srg_pkg::PRI_MASK_0;
		endcase

		push_desc.code  = {1'b0, bank, code_word[13:0]};
		push_desc.xnum  = xnum;
		push_desc.ylast = y_word[15:12];
		push_desc.color = attr_word[5:0];
		push_desc.pri   = pri;
		push_desc.xzoom = srg_pkg::ZOOM_FULL - {2'b00, attr_word[15:12], 2'b00};
		push_desc.yzoom = srg_pkg::ZOOM_FULL - {2'b00, attr_word[11:8], 2'b00};
		// flip-screen mirrors the origin against the screen size and inverts the flip bits
		if (flip_screen_q) begin
			push_desc.fx = ~x_word[11];
			push_desc.fy = ~y_word[11];
			push_desc.sx = {1'b0, scr_width_q} - sx_raw - {3'b000, xnum, 4'b0000};
			push_desc.sy = {1'b0, scr_height_q} - sy_raw - {3'b000, ynum, 4'b0000};
		end else begin
			push_desc.fx = x_word[11];
			push_desc.fy = y_word[11];
			push_desc.sx = sx_raw;
			push_desc.sy = sy_raw;
		end
	end

	// hidden sprites are taken and dropped
	assign in_ready = push_ready;
	assign push     = in_valid && push_ready && !hide;

endmodule

>>> rtl/srg_queue.sv
module srg_queue #(
	parameter int Depth = srg_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	output logic               wr_ready,
	input  srg_pkg::srg_desc_t wr_desc,
	output logic               rd_valid,
	input  logic               rd_ready,
	output srg_pkg::srg_desc_t rd_desc
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	srg_pkg::srg_desc_t slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign wr_ready = count_q != CntW'(Depth);
	assign rd_valid = count_q != '0;
	assign rd_desc  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_desc;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/srg_back.sv
module srg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  srg_pkg::srg_desc_t q_desc,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [18:0]        row_code,
	output logic signed [11:0] row_y,
	output logic signed [11:0] x_origin,
	output logic [4:0]         tiles_across,
	output logic               flip_x,
	output logic               flip_y,
	output logic [5:0]         color,
	output logic [7:0]         priority_mask,
	output logic [7:0]         x_zoom,
	output logic [16:0]        scale_x,
	output logic [16:0]        scale_y,
	output logic               last_row
);

	logic               busy_q;
	srg_pkg::srg_desc_t desc_q;
	logic [3:0]         k_q;
	logic [3:0]         y_q;
	logic [18:0]        code_q;
	logic               out_valid_q;

	logic        load;
	logic        last;
	logic        pop;
	logic [11:0] yprod;

	// a row moves to the output register when it is empty or being drained
	assign load    = busy_q && (!out_valid_q || out_ready);
	assign last    = k_q == desc_q.ylast;
	assign q_ready = !busy_q || (load && last);
	assign pop     = q_valid && q_ready;
	assign yprod   = y_q * desc_q.yzoom;

	// row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			busy_q <= 1'b1;
		end else if (load && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= q_desc;
			k_q    <= '0;
			y_q    <= q_desc.fy ? q_desc.ylast : '0;
			code_q <= q_desc.code;
		end else if (load) begin
			k_q    <= k_q + 1'b1;
			y_q    <= desc_q.fy ? y_q - 1'b1 : y_q + 1'b1;
			code_q <= code_q + {14'b0, desc_q.xnum};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_code      <= code_q;
			row_y         <= desc_q.sy + {3'b000, yprod[11:3]};
			x_origin      <= desc_q.sx;
			tiles_across  <= desc_q.xnum;
			flip_x        <= desc_q.fx;
			flip_y        <= desc_q.fy;
			color         <= desc_q.color;
			priority_mask <= desc_q.pri;
			x_zoom        <= desc_q.xzoom;
			scale_x       <= srg_pkg::scale_of(desc_q.xzoom);
			scale_y       <= srg_pkg::scale_of(desc_q.yzoom);
			last_row      <= last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/sprite_row_generator.sv
// Channel | Direction | Handshake             | Beat
// cfg     | in        | cfg_we                | cfg_index, cfg_data (one register)
// in      | in        | in_valid / in_ready   | x_word, y_word, attr_word, code_word
// out     | out       | out_valid / out_ready | one tile row of a sprite
//
// The decode front takes one list entry per cycle while the descriptor queue
// has room; hidden entries are taken and dropped there.
// The row sequencer emits one row per cycle while out_ready is high and a
// descriptor is queued, so a sprite yields tiles-down rows (1..16); the queue lets decode run ahead.
// Each entry passes through a queue slot, the sequencer descriptor register and the output register.
// Reset clears the queue, the sequencer and the output valid, and loads the
// configuration reset values (bank 0, no flip, 320 x 240).
module sprite_row_generator #(
	parameter int QueueDepth = srg_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [srg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [15:0]                    x_word,
	input  logic [15:0]                    y_word,
	input  logic [15:0]                    attr_word,
	input  logic [15:0]                    code_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [18:0]                    row_code,
	output logic signed [11:0]             row_y,
	output logic signed [11:0]             x_origin,
	output logic [4:0]                     tiles_across,
	output logic                           flip_x,
	output logic                           flip_y,
	output logic [5:0]                     color,
	output logic [7:0]                     priority_mask,
	output logic [7:0]                     x_zoom,
	output logic [16:0]                    scale_x,
	output logic [16:0]                    scale_y,
	output logic                           last_row
);

	logic               push;
	logic               push_ready;
	srg_pkg::srg_desc_t push_desc;
	logic               q_valid;
	logic               q_ready;
	srg_pkg::srg_desc_t q_desc;

	// decode and configuration
	srg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_word     (x_word),
		.y_word     (y_word),
		.attr_word  (attr_word),
		.code_word  (code_word),
		.push       (push),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	// descriptor queue
	srg_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_ready (push_ready),
		.wr_desc  (push_desc),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_desc  (q_desc)
	);

	// row sequencer and output register
	srg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_desc        (q_desc),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.row_code      (row_code),
		.row_y         (row_y),
		.x_origin      (x_origin),
		.tiles_across  (tiles_across),
		.flip_x        (flip_x),
		.flip_y        (flip_y),
		.color         (color),
		.priority_mask (priority_mask),
		.x_zoom        (x_zoom),
		.scale_x       (scale_x),
		.scale_y       (scale_y),
		.last_row      (last_row)
	);

endmodule

>>> rtl/srg_checker.sv
module srg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [18:0]        row_code,
	input logic signed [11:0] x_origin,
	input logic [4:0]         tiles_across,
	input logic [7:0]         x_zoom,
	input logic               last_row
);

	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_code))
		else $error("output beat changed while stalled");

	// rows of one sprite follow without a gap
	a_row_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=> out_valid)
		else $error("gap inside a sprite");

	// tile codes advance by the row width
	a_code_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=>
		row_code == 19'($past(row_code) + 19'($past(tiles_across))))
		else $error("row code step wrong");

	// per-sprite fields stay constant across rows
	a_sprite_const: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=>
		x_origin == $past(x_origin) && tiles_across == $past(tiles_across))
		else $error("sprite fields changed between rows");

	// decoded ranges
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tiles_across != 5'd0 && tiles_across <= 5'd16 &&
		x_zoom >= 8'd68 && x_zoom <= 8'd128)
		else $error("decoded field out of range");

endmodule

bind sprite_row_generator srg_checker u_srg_checker (.*);
